// File: design/interpolated_random_noise_macros.svh
// ----------------------------------------------------------------------------
// interpolated random noise assertion macros
// shared concurrent assertion forms used by the checker
// ----------------------------------------------------------------------------
`ifndef INTERPOLATED_RANDOM_NOISE_MACROS_SVH
`define INTERPOLATED_RANDOM_NOISE_MACROS_SVH

// clocked assertion, quiet while reset is held
`define IRN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define IRN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/irn_pkg.sv
// ----------------------------------------------------------------------------
// irn_pkg
// widths, codes and controller/datapath command types for the noise source
// ----------------------------------------------------------------------------
package irn_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int OUT_WIDTH   = 24;
  localparam int WORD_W      = 32;
  localparam int VAL_W       = 64;
  localparam int PERIOD_W    = 16;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // multiplier operand 2p-1, numerator a*(2p-1), divisor p*p
  localparam int MUL_W = COUNT_WIDTH + 1;
  localparam int NUM_W = VAL_W + MUL_W;
  localparam int DEN_W = 2 * COUNT_WIDTH;
  localparam int CNT_W = $clog2(NUM_W);

  localparam int IN_TDATA_W  = ((WORD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_WIDTH + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = CFG_IDX_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_HOLD   = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_QUAD   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    NUM_KEEP = 2'd0,
    NUM_A    = 2'd1,
    NUM_A2   = 2'd2
  } num_sel_e;

  typedef enum logic {
    DEN_P  = 1'b0,
    DEN_PP = 1'b1
  } den_sel_e;

  typedef struct packed {
    logic     accept;
    logic     seg_start;
    logic     prep;
    logic     mul_step;
    logic     div_load;
    num_sel_e num_sel;
    den_sel_e den_sel;
    logic     div_step;
    logic     store_step;
    logic     store_change;
    logic     tick;
  } cmd_t;

  typedef struct packed {
    logic  samples_zero;
    mode_e mode;
    logic  out_free;
  } status_t;

endpackage

// File: design/irn_ctrl.sv
// ----------------------------------------------------------------------------
// irn_ctrl
// sequencer for sample ticks, segment setup, multiply and divide iterations
// ----------------------------------------------------------------------------
module irn_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  irn_pkg::status_t status_i,
  output irn_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_PREP,
    S_MUL,
    S_LDA,
    S_DIVA,
    S_STA,
    S_LDB,
    S_DIVB,
    S_STB,
    S_TICK
  } state_e;

  state_e                    state_q, state_d;
  logic [irn_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      mul_last, div_last, quad;

  assign mul_last   = (cnt_q == irn_pkg::CNT_W'(irn_pkg::MUL_W - 1));
  assign div_last   = (cnt_q == irn_pkg::CNT_W'(irn_pkg::NUM_W - 1));
  assign quad       = (status_i.mode == irn_pkg::MODE_QUAD);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = status_i.samples_zero ? S_START : S_TICK;
        end
      end
      S_START: begin
        cmd_o.seg_start = 1'b1;
        state_d = (status_i.mode == irn_pkg::MODE_HOLD) ? S_TICK : S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d = '0;
        state_d = quad ? S_MUL : S_LDA;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q + irn_pkg::CNT_W'(1);
        if (mul_last) begin
          state_d = S_LDA;
        end
      end
      S_LDA: begin
        cmd_o.div_load = 1'b1;
        cmd_o.num_sel  = quad ? irn_pkg::NUM_KEEP : irn_pkg::NUM_A;
        cmd_o.den_sel  = quad ? irn_pkg::DEN_PP : irn_pkg::DEN_P;
        cnt_d = '0;
        state_d = S_DIVA;
      end
      S_DIVA: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + irn_pkg::CNT_W'(1);
        if (div_last) begin
          state_d = S_STA;
        end
      end
      S_STA: begin
        cmd_o.store_step = 1'b1;
        state_d = quad ? S_LDB : S_TICK;
      end
      S_LDB: begin
        cmd_o.div_load = 1'b1;
        cmd_o.num_sel  = irn_pkg::NUM_A2;
        cmd_o.den_sel  = irn_pkg::DEN_PP;
        cnt_d = '0;
        state_d = S_DIVB;
      end
      S_DIVB: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + irn_pkg::CNT_W'(1);
        if (div_last) begin
          state_d = S_STB;
        end
      end
      S_STB: begin
        cmd_o.store_change = 1'b1;
        state_d = S_TICK;
      end
      S_TICK: begin
        if (status_i.out_free) begin
          cmd_o.tick = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: design/irn_dp.sv
// ----------------------------------------------------------------------------
// irn_dp
// noise state, config registers, shift-add multiplier, restoring divider
// and the output register
// ----------------------------------------------------------------------------
module irn_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [irn_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [irn_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic [irn_pkg::WORD_W-1:0]       word_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic signed [irn_pkg::OUT_WIDTH-1:0] out_data_o,
  input  irn_pkg::cmd_t                    cmd_i,
  output irn_pkg::status_t                 status_o
);

  localparam int VW = irn_pkg::VAL_W;
  localparam int OW = irn_pkg::OUT_WIDTH;
  localparam int CW = irn_pkg::COUNT_WIDTH;
  localparam int NW = irn_pkg::NUM_W;
  localparam int DW = irn_pkg::DEN_W;
  localparam int MW = irn_pkg::MUL_W;
  localparam logic [31:0] CMAX = 32'((64'd1 << CW) - 64'd1);
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? VMIN : VMAX;
    end
    return s[VW-1:0];
  endfunction

  function automatic logic signed [VW-1:0] sat_sub(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} - {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? VMIN : VMAX;
    end
    return s[VW-1:0];
  endfunction

  // quotient magnitude with sign, saturating to 64 bits
  function automatic logic signed [VW-1:0] to_term(input logic [NW-1:0] q,
                                                   input logic neg);
    logic over;
    logic [VW-1:0] mag;
    over = |q[NW-1:VW-1];
    mag  = {1'b0, q[VW-2:0]};
    if (neg) begin
      return over ? VMIN : -mag;
    end
    return over ? VMAX : mag;
  endfunction

  logic [irn_pkg::PERIOD_W-1:0]       period_q;
  logic [irn_pkg::MODE_W-1:0]         mode_q;
  logic [irn_pkg::WORD_W-1:0]         word_q;
  logic [irn_pkg::WORD_W-1:0]         tgt_q;
  logic signed [VW-1:0]               cur_q, step_q, chg_q, diff_q;
  logic [CW-1:0]                      left_q;
  logic [VW-1:0]                      mag_q;
  logic                               neg_q;
  logic [DW-1:0]                      pp_q, den_q;
  logic [MW-1:0]                      mul_q;
  logic [NW-1:0]                      num_q;
  logic [DW-1:0]                      rem_q;
  logic                               out_valid_q;
  logic signed [OW-1:0]               out_data_q;

  logic [31:0]          per32;
  logic [CW-1:0]        p_eff;
  logic signed [VW-1:0] word_val, tgt_val;
  logic [DW:0]          rem_sh;
  logic                 qbit;
  logic signed [VW-1:0] cur_d, step_d;
  logic [OW:0]          top_bits;
  logic signed [OW-1:0] out_d;
  irn_pkg::mode_e       mode_eff;

  always_comb begin
    per32 = 32'(period_q);
    if (period_q == '0) begin
      per32 = 32'd1;
    end else if (per32 > CMAX) begin
      per32 = CMAX;
    end
    p_eff = per32[CW-1:0];
  end

  always_comb begin
    case (mode_q)
      irn_pkg::MODE_HOLD:   mode_eff = irn_pkg::MODE_HOLD;
      irn_pkg::MODE_LINEAR: mode_eff = irn_pkg::MODE_LINEAR;
      default:              mode_eff = irn_pkg::MODE_QUAD;
    endcase
  end

  // Q1.31 word placed as Q2.62
  assign word_val = {word_q[irn_pkg::WORD_W-1], word_q, {(VW-irn_pkg::WORD_W-1){1'b0}}};
  assign tgt_val  = {tgt_q[irn_pkg::WORD_W-1], tgt_q, {(VW-irn_pkg::WORD_W-1){1'b0}}};

  assign rem_sh = {rem_q, num_q[NW-1]};
  assign qbit   = (rem_sh >= {1'b0, den_q});

  always_comb begin
    cur_d  = cur_q;
    step_d = step_q;
    if (mode_eff != irn_pkg::MODE_HOLD) begin
      cur_d = sat_add(cur_q, step_q);
    end
    if (mode_eff == irn_pkg::MODE_QUAD) begin
      step_d = sat_add(step_q, chg_q);
    end
    top_bits = cur_d[VW-1:VW-1-OW];
    if (top_bits[OW] != top_bits[OW-1]) begin
      out_d = top_bits[OW] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    end else begin
      out_d = top_bits[OW-1:0];
    end
  end

  assign status_o.samples_zero = (left_q == '0);
  assign status_o.mode         = mode_eff;
  assign status_o.out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o           = out_valid_q;
  assign out_data_o            = out_data_q;

  // control state and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= irn_pkg::PERIOD_W'(441);
      mode_q      <= irn_pkg::MODE_HOLD;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      tgt_q       <= '0;
      step_q      <= '0;
      chg_q       <= '0;
      left_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          irn_pkg::REG_PERIOD: period_q <= cfg_wdata_i[irn_pkg::PERIOD_W-1:0];
          irn_pkg::REG_MODE:   mode_q   <= cfg_wdata_i[irn_pkg::MODE_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.seg_start) begin
        tgt_q  <= word_q;
        left_q <= p_eff;
        if (mode_eff == irn_pkg::MODE_HOLD) begin
          cur_q <= tgt_val;
        end
      end
      if (cmd_i.store_step) begin
        step_q <= to_term(num_q, neg_q);
      end
      if (cmd_i.store_change) begin
        chg_q <= to_term(num_q, !neg_q);
      end
      if (cmd_i.tick) begin
        cur_q       <= cur_d;
        step_q      <= step_d;
        left_q      <= left_q - CW'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // arithmetic payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      word_q <= word_i;
    end
    if (cmd_i.seg_start) begin
      diff_q <= sat_sub(word_val, cur_q);
      pp_q   <= DW'(p_eff) * DW'(p_eff);
    end
    if (cmd_i.prep) begin
      neg_q <= diff_q[VW-1];
      mag_q <= diff_q[VW-1] ? -diff_q : diff_q;
      mul_q <= {p_eff, 1'b0} - MW'(1);
      num_q <= '0;
    end
    // msb-first shift-add for a * (2p - 1)
    if (cmd_i.mul_step) begin
      num_q <= {num_q[NW-2:0], 1'b0} + (mul_q[MW-1] ? NW'(mag_q) : NW'(0));
      mul_q <= {mul_q[MW-2:0], 1'b0};
    end
    if (cmd_i.div_load) begin
      rem_q <= '0;
      den_q <= (cmd_i.den_sel == irn_pkg::DEN_PP) ? pp_q : DW'(p_eff);
      case (cmd_i.num_sel)
        irn_pkg::NUM_A:  num_q <= NW'(mag_q);
        irn_pkg::NUM_A2: num_q <= NW'({mag_q, 1'b0});
        default: ;
      endcase
    end
    // one quotient bit per cycle
    if (cmd_i.div_step) begin
      rem_q <= qbit ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
      num_q <= {num_q[NW-2:0], qbit};
    end
    if (cmd_i.tick) begin
      out_data_q <= out_d;
    end
  end

endmodule

// File: design/interpolated_random_noise.sv
// ----------------------------------------------------------------------------
// interpolated_random_noise
// low-frequency random noise with hold, linear and quadratic interpolation
// ----------------------------------------------------------------------------
// Each input request is one sample tick and yields exactly one output sample.
// A tick inside a segment is accepted, then updated into the output register
// once it is free. A tick that starts a segment first latches the target; in
// linear and quadratic mode the setup then runs one restoring divider that
// makes one quotient bit per cycle over an 81-bit numerator, once for the
// linear slope and twice for the quadratic terms, the quadratic setup after a
// shift-add multiply by 2p-1. The output register lets a new request be
// accepted while the previous sample waits. Config must be written only while
// idle; the block itself does not enforce it.
module interpolated_random_noise (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [irn_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [irn_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [irn_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [31:0] random_word
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [irn_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // [23:0] sample_out
);

  irn_pkg::cmd_t                        cmd;
  irn_pkg::status_t                     status;
  logic signed [irn_pkg::OUT_WIDTH-1:0] sample;

  irn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  irn_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .word_i      (s_axis_tdata[irn_pkg::WORD_W-1:0]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (sample),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  assign m_axis_tdata = irn_pkg::OUT_TDATA_W'(unsigned'(sample));

endmodule

// File: design/irn_checker.sv
// ----------------------------------------------------------------------------
// irn_checker
// port-level checks on request flow through the noise source
// ----------------------------------------------------------------------------
`include "interpolated_random_noise_macros.svh"

module irn_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [irn_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic       s_acc, m_acc, m_stall;
  logic [1:0] pend_q, pend_d;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign m_acc   = m_axis_tvalid && m_axis_tready;
  assign m_stall = m_axis_tvalid && !m_axis_tready;

  // requests taken in but not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (s_acc && !m_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (m_acc && !s_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `IRN_ASSERT(out_valid_holds, m_stall |=> m_axis_tvalid, "output valid dropped in a stall")
  `IRN_ASSERT(out_data_holds, m_stall |=> $stable(m_axis_tdata), "output data moved in a stall")
  `IRN_ASSERT(busy_after_accept, s_acc |=> !s_axis_tready, "input ready while busy")
  `IRN_ASSERT(no_invented_output, m_acc |-> pend_q != 2'd0, "output with no request pending")
  `IRN_ASSERT(pending_bound, pend_q != 2'd3, "more than two requests in flight")

endmodule

bind interpolated_random_noise irn_checker u_irn_checker (.*);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: interpolated random noise source testbench
// Feeds random sample-tick words through the input stream under several
// period and mode settings. A local fixed-point predictor produces the
// expected sample for every accepted tick, and each output sample is checked
// in order. Both stream sides idle at random for part of the run.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES  = 200;

  localparam logic [irn_pkg::PERIOD_W-1:0]  PERIOD_RESET = 16'd441;
  localparam logic [irn_pkg::MODE_W-1:0]    MODE_SPARE   = 2'd3;
  localparam logic [irn_pkg::CFG_IDX_W-1:0] REG_NONE_LO  = 2'd2;
  localparam logic [irn_pkg::CFG_IDX_W-1:0] REG_NONE_HI  = 2'd3;

  localparam logic [31:0]        CNT_MAX = (32'd1 << irn_pkg::COUNT_WIDTH) - 32'd1;
  localparam logic signed [63:0] Q_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN   = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] OUT_HI  = (64'sd1 <<< (irn_pkg::OUT_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_LO  = -OUT_HI - 64'sd1;

  typedef struct packed {
    logic [31:0]                   tick;
    logic [irn_pkg::OUT_WIDTH-1:0] sample;
  } sample_t;

  logic                            clk_i;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [irn_pkg::CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [irn_pkg::CFG_DATA_W-1:0]  cfg_wdata_i   = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [irn_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [31:0] random_word
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [irn_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // [23:0] sample_out

  // predictor state and its copy of the registers
  logic signed [irn_pkg::VAL_W-1:0] acc_val    = '0;
  logic signed [irn_pkg::VAL_W-1:0] slope      = '0;
  logic signed [irn_pkg::VAL_W-1:0] curve      = '0;
  logic [irn_pkg::WORD_W-1:0]       tgt_word   = '0;
  logic [irn_pkg::COUNT_WIDTH-1:0]  ticks_left = '0;
  logic [irn_pkg::PERIOD_W-1:0]     period_reg = PERIOD_RESET;
  logic [irn_pkg::MODE_W-1:0]       mode_reg   = irn_pkg::MODE_HOLD;

  logic [irn_pkg::WORD_W-1:0] word_q[$];
  sample_t                    sample_q[$];
  sample_t                    head;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned n_queued = 0, n_ticks = 0, n_phases = 0, n_checked = 0;
  int unsigned starts_hold = 0, starts_linear = 0, starts_quad = 0, clipped = 0;
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;

  interpolated_random_noise dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [63:0] clip65(input logic signed [64:0] s);
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    return clip65({a[63], a} + {b[63], b});
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    return clip65({a[63], a} - {b[63], b});
  endfunction

  // signed Q1.31 word to Q2.62
  function automatic logic signed [63:0] to_q62(input logic [irn_pkg::WORD_W-1:0] w);
    return {w[31], w, 31'd0};
  endfunction

  // floor(mag * mult / den), all ones when the quotient leaves 64 bits
  function automatic logic [63:0] scaled_quotient(input logic [63:0] mag,
                                                  input logic [31:0] mult,
                                                  input logic [63:0] den);
    logic [127:0] q;
    q = ({64'd0, mag} * {96'd0, mult}) / {64'd0, den};
    return (q[127:64] != '0) ? '1 : q[63:0];
  endfunction

  function automatic logic signed [63:0] from_mag(input logic [63:0] mag, input logic neg);
    if (!neg) return mag[63] ? Q_MAX : $signed(mag);
    if (mag > 64'h8000_0000_0000_0000) return Q_MIN;
    return -$signed(mag);
  endfunction

  function automatic logic [irn_pkg::OUT_WIDTH-1:0] next_sample(
      input logic [irn_pkg::WORD_W-1:0] w);
    irn_pkg::mode_e     eff;
    logic [31:0]        per;
    logic [63:0]        pp;
    logic [63:0]        mag;
    logic signed [63:0] diff;
    logic signed [63:0] sh;
    logic               neg;
    eff = (mode_reg == MODE_SPARE) ? irn_pkg::MODE_QUAD : irn_pkg::mode_e'(mode_reg);
    per = (period_reg == '0) ? 32'd1 : 32'(period_reg);
    if (per > CNT_MAX) per = CNT_MAX;
    if (ticks_left == '0) begin
      if (eff == irn_pkg::MODE_HOLD) acc_val = to_q62(tgt_word);
      tgt_word   = w;
      ticks_left = per[irn_pkg::COUNT_WIDTH-1:0];
      diff       = sat_sub(to_q62(w), acc_val);
      case (eff)
        irn_pkg::MODE_HOLD: begin
          starts_hold++;
        end
        irn_pkg::MODE_LINEAR: begin
          slope = diff / $signed({32'd0, per});
          starts_linear++;
        end
        default: begin
          neg   = diff[63];
          mag   = neg ? 64'd0 - diff : diff;
          pp    = {32'd0, per} * {32'd0, per};
          slope = from_mag(scaled_quotient(mag, (per << 1) - 32'd1, pp), neg);
          curve = from_mag(scaled_quotient(mag, 32'd2, pp), !neg);
          starts_quad++;
        end
      endcase
    end
    ticks_left = ticks_left - irn_pkg::COUNT_WIDTH'(1);
    if (eff != irn_pkg::MODE_HOLD) begin
      acc_val = sat_add(acc_val, slope);
      if (eff == irn_pkg::MODE_QUAD) slope = sat_add(slope, curve);
    end
    sh = acc_val >>> (63 - irn_pkg::OUT_WIDTH);
    if (sh > OUT_HI || sh < OUT_LO) clipped++;
    if (sh > OUT_HI) sh = OUT_HI;
    else if (sh < OUT_LO) sh = OUT_LO;
    return sh[irn_pkg::OUT_WIDTH-1:0];
  endfunction

  // ------------------------------------------------------------ driver/monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sample_q.push_back('{tick: n_ticks,
                             sample: next_sample(s_axis_tdata[irn_pkg::WORD_W-1:0])});
        n_ticks++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= irn_pkg::IN_TDATA_W'(word_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (sample_q.size() == 0) begin
          $display("%0t: sample %0d arrived with no tick pending", $time,
                   $signed(m_axis_tdata[irn_pkg::OUT_WIDTH-1:0]));
          error_cnt++;
        end else begin
          head = sample_q.pop_front();
          n_checked++;
          if (m_axis_tdata[irn_pkg::OUT_WIDTH-1:0] !== head.sample) begin
            $display("%0t: tick %0d sample_out expected %0d, actual %0d", $time, head.tick,
                     $signed(head.sample),
                     $signed(m_axis_tdata[irn_pkg::OUT_WIDTH-1:0]));
            error_cnt++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles, %0d samples outstanding", $time,
               cycle_cnt, sample_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ----------------------------------------------------------------- stimulus

  // wait until every queued tick has come back as a sample
  task automatic drain(input int unsigned extra);
    while (word_q.size() != 0 || s_axis_tvalid || sample_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [irn_pkg::CFG_IDX_W-1:0] idx,
                           input logic [irn_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == irn_pkg::REG_PERIOD) period_reg = val;
    else if (idx == irn_pkg::REG_MODE) mode_reg = val[irn_pkg::MODE_W-1:0];
  endtask

  task automatic pick_idle();
    if (n_queued < 667) begin
      send_idle = 38;
      recv_idle = 54;
    end else if (n_queued < 1334) begin
      send_idle = 54;
      recv_idle = 38;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  endtask

  task automatic configure(input logic [irn_pkg::PERIOD_W-1:0] per,
                           input logic [irn_pkg::MODE_W-1:0] mode,
                           input bit spare);
    logic [irn_pkg::CFG_DATA_W-1:0] mode_word;
    drain(DRAIN_CYCLES);
    // upper bits of the mode write are don't-care
    mode_word                      = irn_pkg::CFG_DATA_W'($urandom);
    mode_word[irn_pkg::MODE_W-1:0] = mode;
    write_reg(irn_pkg::REG_PERIOD, per);
    write_reg(irn_pkg::REG_MODE, mode_word);
    if (spare) begin
      write_reg(REG_NONE_LO, irn_pkg::CFG_DATA_W'($urandom));
      write_reg(REG_NONE_HI, irn_pkg::CFG_DATA_W'($urandom));
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pick_idle();
    n_phases++;
  endtask

  task automatic feed(input logic [irn_pkg::WORD_W-1:0] w);
    word_q.push_back(w);
    n_queued++;
  endtask

  function automatic logic [irn_pkg::WORD_W-1:0] noise_word();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    logic [irn_pkg::PERIOD_W-1:0] per;
    logic [irn_pkg::MODE_W-1:0]   mode_pick;
    int unsigned                  len;
    int unsigned                  i;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: hold at period 441, run one whole segment
    pick_idle();
    n_phases++;
    feed(32'h7FFF_FFFF);
    feed(32'h8000_0000);
    for (i = 2; i < 441; i++) feed(noise_word());

    // mode three at period one: full-scale swings saturate the curvature term
    configure(16'd1, MODE_SPARE, 1'b0);
    feed(32'h7FFF_FFFF);
    feed(32'h8000_0000);
    feed(32'h0000_0000);
    configure(16'd2, irn_pkg::MODE_QUAD, 1'b0);
    feed(32'h8000_0000);
    feed(32'h7FFF_FFFF);

    // zero period acts as one; leaves a near full-scale linear step behind
    configure(16'd0, irn_pkg::MODE_LINEAR, 1'b0);
    feed(32'hFFFF_FFFF);
    feed(32'h8000_0000);
    feed(32'h7FFF_FFFF);

    // hold keeps the stale step, then linear mid-segment runs into the clip
    configure(16'd11, irn_pkg::MODE_HOLD, 1'b1);
    feed(noise_word());
    configure(16'd11, irn_pkg::MODE_LINEAR, 1'b0);
    repeat (10) feed(noise_word());

    while (n_queued < 1700) begin
      case ($urandom_range(7))
        0:       per = 16'd0;
        1:       per = 16'd1;
        2:       per = irn_pkg::PERIOD_W'($urandom_range(300, 100));
        default: per = irn_pkg::PERIOD_W'($urandom_range(24, 2));
      endcase
      mode_pick = irn_pkg::MODE_W'($urandom_range(3));
      configure(per, mode_pick, $urandom_range(3) == 0);
      len = $urandom_range(80, 10);
      repeat (len) feed(noise_word());
    end

    // longest period: finish the open segment first so the new one latches
    configure(16'hFFFF, irn_pkg::MODE_QUAD, 1'b0);
    repeat (ticks_left) feed(noise_word());
    repeat (150) feed(noise_word());
    configure(16'hFFFF, irn_pkg::MODE_LINEAR, 1'b0);
    repeat (75) feed(noise_word());
    configure(16'hFFFF, irn_pkg::MODE_HOLD, 1'b0);
    repeat (75) feed(noise_word());

    drain(TAIL_CYCLES);
    $display("%0d ticks over %0d register settings", n_ticks, n_phases);
    $display("segment starts: hold %0d, linear %0d, quad %0d",
             starts_hold, starts_linear, starts_quad);
    $display("%0d samples checked, %0d at the output clip, %0d mismatches",
             n_checked, clipped, error_cnt);
    if (error_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
